// ===== hdl/ttg_pkg.sv =====
package ttg_pkg;

    localparam int COORD_BITS       = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int DIFF_SHIFT  = (COORD_BITS > 24) ? COORD_BITS - 24 : 0;
    localparam int OUT_LIMIT   = (NORMAL_FRAC_BITS >= 15) ? 32767 : (1 << NORMAL_FRAC_BITS);
    localparam int DIFF_BITS   = COORD_BITS + 1 - DIFF_SHIFT;
    localparam int TG_FIT      = 20;
    localparam int O_FIT       = 30;

    // Wide working words for the tangent arithmetic
    localparam int TG_BITS  = 2 * DIFF_BITS + 2;
    localparam int DOT_BITS = TG_FIT + 1 + 16 + 2;
    localparam int O_BITS   = DOT_BITS + 17 + 1;
    localparam int SUM_BITS = 2 * O_FIT + 2;
    localparam int LEN_BITS = SUM_BITS / 2;
    localparam int QN_BITS  = O_FIT + NORMAL_FRAC_BITS;

    typedef enum logic [1:0] {
        CORNER_OLD = 2'd0,
        CORNER_MID = 2'd1,
        CORNER_NEW = 2'd2
    } corner_t;

    typedef struct packed {
        logic                          restart;
        logic signed [COORD_BITS-1:0]  pos_x;
        logic signed [COORD_BITS-1:0]  pos_y;
        logic signed [COORD_BITS-1:0]  pos_z;
        logic signed [COORD_BITS-1:0]  tex_u;
        logic signed [COORD_BITS-1:0]  tex_v;
        logic signed [15:0]            norm_x;
        logic signed [15:0]            norm_y;
        logic signed [15:0]            norm_z;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         corner;
        logic signed [15:0] tan_x;
        logic signed [15:0] tan_y;
        logic signed [15:0] tan_z;
        logic               degenerate;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] px, py, pz, tu, tv;
        logic signed [15:0]           nx, ny, nz;
    } vtx_t;

    // One assembled triangle, passed from the front to the back
    typedef struct packed {
        vtx_t a;
        vtx_t b;
        vtx_t c;
    } tri_t;

    // Truncate-toward-zero right shift
    function automatic logic signed [O_BITS-1:0] shr_tz(
        input logic signed [O_BITS-1:0] v, input logic [6:0] k);
        logic [O_BITS-1:0] m;
        begin
            m = v[O_BITS-1] ? O_BITS'(-v) : O_BITS'(v);
            m = m >> k;
            shr_tz = v[O_BITS-1] ? -$signed(m) : $signed(m);
        end
    endfunction

    function automatic logic [O_BITS-1:0] mag(input logic signed [O_BITS-1:0] v);
        mag = v[O_BITS-1] ? O_BITS'(-v) : O_BITS'(v);
    endfunction

endpackage

// ===== hdl/triangle_tangent_generator.sv =====
// Triangle tangent generator. Vertices arrive on the s_ channel and are
// grouped into triangles (list mode: every three vertices; strip mode: each
// new vertex with the two before it, no winding alternation). The front takes
// one vertex a cycle (it stalls while a finished triangle waits on a full
// queue) into a two-entry triangle queue; the back works out one triangle at
// a time with narrow multipliers, a bit-serial square root and a bit-serial
// divider, and gives three tangent beats, oldest corner first, with last on
// the third. For each triangle the back forms the differences, the tangent
// and its fit, then per corner the dot product and sum of squares, 31
// square-root steps, a divider set-up, three 46-step divisions and the output
// beat (a degenerate corner skips the divisions); an output stall holds it.
// Write topology_mode only while the block is idle.
module triangle_tangent_generator (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  ttg_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ttg_pkg::out_item_t  m_data
);

    logic          topology_mode_reg;
    logic          fq_valid, fq_ready, qb_valid, qb_ready;
    ttg_pkg::tri_t fq_data, qb_data;

    // Always accept a register write beat
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            topology_mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            topology_mode_reg <= cfg_data;
        end
    end

    ttg_front u_front (
        .aclk, .aresetn, .topology_mode(topology_mode_reg),
        .s_valid, .s_ready, .s_data,
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
    );

    ttg_queue u_queue (
        .aclk, .aresetn,
        .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
        .out_valid(qb_valid), .out_ready(qb_ready), .out_data(qb_data)
    );

    ttg_back u_back (
        .aclk, .aresetn,
        .t_valid(qb_valid), .t_ready(qb_ready), .t_data(qb_data),
        .m_valid, .m_ready, .m_data
    );

endmodule

// ===== hdl/ttg_front.sv =====
module ttg_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             topology_mode,
    input  logic             s_valid,
    output logic             s_ready,
    input  ttg_pkg::in_item_t s_data,
    output logic             q_valid,
    input  logic             q_ready,
    output ttg_pkg::tri_t    q_data
);

    ttg_pkg::vtx_t  held_reg [2];
    logic [1:0]     held_count_reg;
    ttg_pkg::vtx_t  v;
    logic [1:0]     cnt;
    logic           fire;

    always_comb begin
        v.px = s_data.pos_x; v.py = s_data.pos_y; v.pz = s_data.pos_z;
        v.tu = s_data.tex_u; v.tv = s_data.tex_v;
        v.nx = s_data.norm_x; v.ny = s_data.norm_y; v.nz = s_data.norm_z;
        cnt = s_data.restart ? 2'd0 : held_count_reg;
    end

    // A triangle completes only when the queue can take it
    assign fire    = (cnt == 2'd2);
    assign s_ready = !fire || q_ready;
    assign q_valid = s_valid && fire;
    assign q_data  = '{a: held_reg[0], b: held_reg[1], c: v};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= 2'd0;
        end else if (s_valid && s_ready) begin
            if (!fire) begin
                held_count_reg <= cnt + 2'd1;
            end else if (topology_mode) begin
                held_count_reg <= 2'd2;
            end else begin
                held_count_reg <= 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            if (!fire) begin
                held_reg[cnt[0]] <= v;
            end else if (topology_mode) begin
                held_reg[0] <= held_reg[1];
                held_reg[1] <= v;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg != 2'd3)
        else $error("held count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> s_valid)
        else $error("triangle without vertex");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !topology_mode && fire) |=> held_count_reg == 2'd0)
        else $error("list mode did not drop held vertices");

endmodule

// ===== hdl/ttg_queue.sv =====
module ttg_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  ttg_pkg::tri_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ttg_pkg::tri_t out_data
);

    ttg_pkg::tri_t mem_reg [2];
    logic          wptr_reg, rptr_reg;
    logic [1:0]    count_reg;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (in_valid && in_ready) wptr_reg <= !wptr_reg;
            if (out_valid && out_ready) rptr_reg <= !rptr_reg;
            count_reg <= count_reg + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) mem_reg[wptr_reg] <= in_data;
    end

    assert property (@(posedge aclk) disable iff (!aresetn) count_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0) |-> (wptr_reg == rptr_reg))
        else $error("queue pointers disagree when empty");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2) |-> (wptr_reg == rptr_reg))
        else $error("queue pointers disagree when full");

endmodule

// ===== hdl/ttg_back.sv =====
module ttg_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               t_valid,
    output logic               t_ready,
    input  ttg_pkg::tri_t      t_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ttg_pkg::out_item_t m_data
);
    localparam int OB  = ttg_pkg::O_BITS;
    localparam int LB  = ttg_pkg::LEN_BITS;
    localparam int QB  = ttg_pkg::QN_BITS;
    localparam int SB  = ttg_pkg::SUM_BITS;
    localparam int DB  = ttg_pkg::DIFF_BITS;
    localparam int TB  = ttg_pkg::TG_FIT + 1;
    localparam int DTB = ttg_pkg::DOT_BITS;
    localparam int PB  = 2 * ttg_pkg::O_FIT;

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_TAN, S_TFIT, S_DOT, S_ORTH, S_OFIT, S_SQ, S_SQRT,
        S_DIVI, S_DIV, S_OUT
    } state_t;

    state_t state_reg;
    ttg_pkg::tri_t tri_reg;
    logic signed [OB-1:0] e_reg [3];
    logic signed [OB-1:0] w_reg [3];
    logic signed [OB-1:0] s_reg [2];
    logic signed [OB-1:0] t_reg [2];
    logic signed [OB-1:0] tg_reg [3];
    logic signed [OB-1:0] o_reg [3];
    logic signed [OB-1:0] dot_reg;
    logic signed [15:0]   n_reg [3];
    logic [1:0]           corner_reg;
    logic [1:0]           comp_reg;
    logic [SB-1:0]        rem_reg;
    logic [LB-1:0]        root_reg;
    logic [6:0]           step_reg;
    logic [QB+1:0]        num_reg;
    logic [QB:0]          quo_reg;
    logic [LB:0]          drem_reg;
    logic signed [15:0]   tan_reg [3];
    ttg_pkg::out_item_t   m_data_reg;
    logic                 m_valid_reg;

    // Combinational helpers
    logic [OB-1:0] mx;
    logic [6:0]    fit_k;
    logic [6:0]    lim;
    logic [SB+1:0] trial;
    logic [LB+1:0] dtrial;
    logic [1:0]    lane;
    logic [OB-1:0] sq_mag;
    logic [PB-1:0] sq_prod;
    logic signed [2*DB-1:0] det_l, det_r;
    logic signed [2*DB-1:0] ws [3];
    logic signed [2*DB-1:0] et [3];
    logic signed [TB+15:0]  dot_term;
    logic signed [DTB+15:0] nd [3];

    assign t_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        mx = ttg_pkg::mag(o_reg[0]);
        if (ttg_pkg::mag(o_reg[1]) > mx) mx = ttg_pkg::mag(o_reg[1]);
        if (ttg_pkg::mag(o_reg[2]) > mx) mx = ttg_pkg::mag(o_reg[2]);
        lim = (state_reg == S_TFIT) ? 7'(ttg_pkg::TG_FIT) : 7'(ttg_pkg::O_FIT);
        fit_k = 7'd0;
        for (int i = OB - 1; i >= 0; i--) begin
            if (fit_k == 7'd0 && mx[i] && i >= int'(lim)) fit_k = 7'(i) - lim + 7'd1;
        end
        trial  = {2'b00, rem_reg} - ({2'b00, SB'(root_reg)} << (step_reg + 7'd1))
                 - ({2'b00, {SB{1'b0}}} | (SB + 2)'(1) << (2 * step_reg));
        dtrial = {drem_reg, num_reg[QB+1]} - (LB + 2)'(root_reg);
        // Narrow products: operands carry only their meaningful bits
        lane     = (comp_reg == 2'd3) ? 2'd0 : comp_reg;
        sq_mag   = ttg_pkg::mag(o_reg[lane]);
        sq_prod  = PB'(sq_mag[ttg_pkg::O_FIT-1:0]) * PB'(sq_mag[ttg_pkg::O_FIT-1:0]);
        det_l    = (2 * DB)'($signed(t_reg[0][DB-1:0])) * (2 * DB)'($signed(s_reg[1][DB-1:0]));
        det_r    = (2 * DB)'($signed(t_reg[1][DB-1:0])) * (2 * DB)'($signed(s_reg[0][DB-1:0]));
        dot_term = (TB + 16)'($signed(tg_reg[lane][TB-1:0])) * (TB + 16)'(n_reg[lane]);
        for (int i = 0; i < 3; i++) begin
            ws[i] = (2 * DB)'($signed(w_reg[i][DB-1:0])) * (2 * DB)'($signed(s_reg[1][DB-1:0]));
            et[i] = (2 * DB)'($signed(e_reg[i][DB-1:0])) * (2 * DB)'($signed(t_reg[1][DB-1:0]));
            nd[i] = (DTB + 16)'(n_reg[i]) * (DTB + 16)'($signed(dot_reg[DTB-1:0]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (t_valid) begin
                        tri_reg    <= t_data;
                        corner_reg <= ttg_pkg::CORNER_OLD;
                        state_reg  <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    e_reg[0] <= ttg_pkg::shr_tz(OB'(tri_reg.b.px) - OB'(tri_reg.a.px), 7'(ttg_pkg::DIFF_SHIFT));
                    e_reg[1] <= ttg_pkg::shr_tz(OB'(tri_reg.b.py) - OB'(tri_reg.a.py), 7'(ttg_pkg::DIFF_SHIFT));
                    e_reg[2] <= ttg_pkg::shr_tz(OB'(tri_reg.b.pz) - OB'(tri_reg.a.pz), 7'(ttg_pkg::DIFF_SHIFT));
                    w_reg[0] <= ttg_pkg::shr_tz(OB'(tri_reg.c.px) - OB'(tri_reg.a.px), 7'(ttg_pkg::DIFF_SHIFT));
                    w_reg[1] <= ttg_pkg::shr_tz(OB'(tri_reg.c.py) - OB'(tri_reg.a.py), 7'(ttg_pkg::DIFF_SHIFT));
                    w_reg[2] <= ttg_pkg::shr_tz(OB'(tri_reg.c.pz) - OB'(tri_reg.a.pz), 7'(ttg_pkg::DIFF_SHIFT));
                    s_reg[0] <= ttg_pkg::shr_tz(OB'(tri_reg.b.tu) - OB'(tri_reg.a.tu), 7'(ttg_pkg::DIFF_SHIFT));
                    s_reg[1] <= ttg_pkg::shr_tz(OB'(tri_reg.b.tv) - OB'(tri_reg.a.tv), 7'(ttg_pkg::DIFF_SHIFT));
                    t_reg[0] <= ttg_pkg::shr_tz(OB'(tri_reg.c.tu) - OB'(tri_reg.a.tu), 7'(ttg_pkg::DIFF_SHIFT));
                    t_reg[1] <= ttg_pkg::shr_tz(OB'(tri_reg.c.tv) - OB'(tri_reg.a.tv), 7'(ttg_pkg::DIFF_SHIFT));
                    state_reg <= S_TAN;
                end
                S_TAN: begin
                    // Sign from the texture determinant, folded into the tangent
                    for (int i = 0; i < 3; i++) begin
                        if (det_l < det_r)
                            o_reg[i] <= OB'(et[i]) - OB'(ws[i]);
                        else
                            o_reg[i] <= OB'(ws[i]) - OB'(et[i]);
                    end
                    state_reg <= S_TFIT;
                end
                S_TFIT: begin
                    for (int i = 0; i < 3; i++) tg_reg[i] <= ttg_pkg::shr_tz(o_reg[i], fit_k);
                    state_reg <= S_DOT;
                end
                S_DOT: begin
                    unique case (corner_reg)
                        ttg_pkg::CORNER_OLD: n_reg <= '{tri_reg.a.nx, tri_reg.a.ny, tri_reg.a.nz};
                        ttg_pkg::CORNER_MID: n_reg <= '{tri_reg.b.nx, tri_reg.b.ny, tri_reg.b.nz};
                        default:             n_reg <= '{tri_reg.c.nx, tri_reg.c.ny, tri_reg.c.nz};
                    endcase
                    state_reg <= S_ORTH;
                    dot_reg <= '0;
                    comp_reg <= 2'd0;
                end
                S_ORTH: begin
                    // Accumulate the dot product one lane a cycle, then form o
                    if (comp_reg != 2'd3) begin
                        dot_reg  <= dot_reg + OB'(dot_term);
                        comp_reg <= comp_reg + 2'd1;
                    end else begin
                        for (int i = 0; i < 3; i++)
                            o_reg[i] <= (tg_reg[i] <<< ttg_pkg::NORMAL_FRAC_BITS) - OB'(nd[i]);
                        state_reg <= S_OFIT;
                    end
                end
                S_OFIT: begin
                    for (int i = 0; i < 3; i++) o_reg[i] <= ttg_pkg::shr_tz(o_reg[i], fit_k);
                    comp_reg <= 2'd0;
                    rem_reg  <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ: begin
                    if (comp_reg != 2'd3) begin
                        rem_reg  <= rem_reg + SB'(sq_prod);
                        comp_reg <= comp_reg + 2'd1;
                    end else begin
                        root_reg  <= '0;
                        step_reg  <= 7'(LB - 1);
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    // One result bit a cycle: restoring square root
                    if (!trial[SB+1]) begin
                        rem_reg  <= trial[SB-1:0];
                        root_reg <= root_reg | (LB'(1) << step_reg);
                    end
                    if (step_reg == 7'd0) state_reg <= S_DIVI;
                    else step_reg <= step_reg - 7'd1;
                end
                S_DIVI: begin
                    if (root_reg == '0) begin
                        for (int i = 0; i < 3; i++) tan_reg[i] <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        comp_reg  <= 2'd0;
                        num_reg   <= ((QB + 2)'(ttg_pkg::mag(o_reg[0])) << ttg_pkg::NORMAL_FRAC_BITS)
                                     + (QB + 2)'(root_reg >> 1);
                        drem_reg  <= '0;
                        quo_reg   <= '0;
                        step_reg  <= 7'(QB + 1);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    // One quotient bit a cycle per component
                    if (!dtrial[LB+1]) begin
                        drem_reg <= dtrial[LB:0];
                        quo_reg  <= {quo_reg[QB-1:0], 1'b1};
                    end else begin
                        drem_reg <= {drem_reg[LB-1:0], num_reg[QB+1]};
                        quo_reg  <= {quo_reg[QB-1:0], 1'b0};
                    end
                    num_reg <= num_reg << 1;
                    if (step_reg != 7'd0) begin
                        step_reg <= step_reg - 7'd1;
                    end else begin
                        state_reg <= S_DIVI;
                    end
                    if (step_reg == 7'd0) begin
                        state_reg <= S_DIV;
                        step_reg  <= 7'(QB + 1);
                        drem_reg  <= '0;
                        quo_reg   <= '0;
                        comp_reg  <= comp_reg + 2'd1;
                        if (comp_reg == 2'd2) state_reg <= S_OUT;
                        num_reg <= ((QB + 2)'(ttg_pkg::mag(o_reg[(comp_reg == 2'd0) ? 1 : 2]))
                                    << ttg_pkg::NORMAL_FRAC_BITS) + (QB + 2)'(root_reg >> 1);
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.corner     <= corner_reg;
                        m_data_reg.tan_x      <= tan_reg[0];
                        m_data_reg.tan_y      <= tan_reg[1];
                        m_data_reg.tan_z      <= tan_reg[2];
                        m_data_reg.degenerate <= (root_reg == '0);
                        m_data_reg.last       <= (corner_reg == ttg_pkg::CORNER_NEW);
                        m_valid_reg           <= 1'b1;
                        corner_reg            <= corner_reg + 2'd1;
                        state_reg <= (corner_reg == ttg_pkg::CORNER_NEW) ? S_IDLE : S_DOT;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            // Capture each finished quotient, saturated and signed
            if (state_reg == S_DIV && step_reg == 7'd0) begin
                logic [QB:0] qf;
                qf = dtrial[LB+1] ? {quo_reg[QB-1:0], 1'b0} : {quo_reg[QB-1:0], 1'b1};
                if (qf > (QB + 1)'(ttg_pkg::OUT_LIMIT)) qf = (QB + 1)'(ttg_pkg::OUT_LIMIT);
                tan_reg[comp_reg] <= o_reg[comp_reg][OB-1] ? -$signed(16'(qf)) : $signed(16'(qf));
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.degenerate) |-> (m_data.tan_x == 0 && m_data.tan_y == 0 && m_data.tan_z == 0))
        else $error("degenerate result carries a tangent");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last == (m_data.corner == ttg_pkg::CORNER_NEW)))
        else $error("last flag out of step with corner");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !t_ready)
        else $error("took a triangle while busy");

endmodule
